### hw/rtl/mwtl_pkg.sv
// shared types and constants for the mixed-width text layout block
package mwtl_pkg;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_ORIGIN_X   = 3'd0,
    REG_ORIGIN_Y   = 3'd1,
    REG_BOX_WIDTH  = 3'd2,
    REG_BOX_HEIGHT = 3'd3,
    REG_FONT_SIZE  = 3'd4,
    REG_OVERLAY    = 3'd5
  } cfg_idx_t;

  localparam logic [7:0]  BYTE_END      = 8'd0;
  localparam logic [7:0]  BYTE_CR       = 8'd13;
  localparam logic [7:0]  LEAD_MIN      = 8'h80;
  localparam logic [7:0]  FONT_SIZE_RST = 8'd16;

  typedef struct packed {
    logic [15:0] origin_x;
    logic [15:0] origin_y;
    logic [15:0] box_width;
    logic [15:0] box_height;
    logic [7:0]  font_size;
    logic        overlay;
  } cfg_t;

  // cursor reload requests raised by origin writes
  typedef struct packed {
    logic ld_x;
    logic ld_y;
  } origin_ld_t;

  typedef struct packed {
    logic [15:0] draw_x;
    logic [15:0] draw_y;
    logic [15:0] glyph_code;
    logic        glyph_wide;
    logic        transparent;
  } result_t;

endpackage

### hw/rtl/mixed_width_text_layout.sv
// top level of the mixed-width text layout block
// path: a text byte is held in the input register, and its result beat in the result register
// throughput: one text byte per cycle while the result register can load, set by the single cursor update stage
// a full result register stalls the input register only while the sink holds off
// reset (rst_n low, synchronous): cursor to origin zero, flags clear, font size 16,
// all other configuration registers zero, no beat pending on either side
module mixed_width_text_layout import mwtl_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] text_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // [15:0] draw_x, [31:16] draw_y, [47:32] glyph_code,
                                  // [48] transparent, [55:49] zero
  output logic        out_tuser,  // [0] glyph_wide
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_t       cfg;
  origin_ld_t ld;
  logic       can_load;
  logic       res_valid;
  result_t    res;

  mwtl_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg),
    .ld        (ld)
  );

  mwtl_layout u_layout (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .cfg       (cfg),
    .ld        (ld),
    .can_load  (can_load),
    .res_valid (res_valid),
    .res       (res)
  );

  mwtl_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (res_valid),
    .res        (res),
    .can_load   (can_load),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // full-width glyphs always carry a lead byte above the threshold
  a_wide_lead: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[47:40] > LEAD_MIN)
    else $error("full-width glyph with invalid lead byte");

  // half-width glyphs are never an end or line-break byte
  a_half_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |->
      out_tdata[47:40] == 8'd0 && out_tdata[39:32] != BYTE_CR &&
      out_tdata[39:32] != BYTE_END)
    else $error("half-width glyph with illegal code");

  // the input only stalls behind a held result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled without a held result");

endmodule

### hw/rtl/mwtl_cfg_regs.sv
// configuration register file of the text layout block
module mwtl_cfg_regs import mwtl_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output cfg_t        cfg,
  output origin_ld_t  ld
);

  cfg_t       cfg_r;
  cfg_t       cfg_nxt;
  origin_ld_t ld_r;
  origin_ld_t ld_nxt;
  logic       wr;
  cfg_idx_t   idx;

  assign cfg_ready = 1'b1;
  assign wr        = cfg_valid & cfg_ready;
  assign idx       = cfg_idx_t'(cfg_index);

  // register decode
  always_comb begin
    cfg_nxt = cfg_r;
    ld_nxt  = '0;
    if (wr) begin
      unique case (idx)
        REG_ORIGIN_X: begin
          cfg_nxt.origin_x = cfg_data;
          ld_nxt.ld_x      = 1'b1;
        end
        REG_ORIGIN_Y: begin
          cfg_nxt.origin_y = cfg_data;
          ld_nxt.ld_y      = 1'b1;
        end
        REG_BOX_WIDTH:  cfg_nxt.box_width  = cfg_data;
        REG_BOX_HEIGHT: cfg_nxt.box_height = cfg_data;
        REG_FONT_SIZE:  cfg_nxt.font_size  = cfg_data[7:0];
        REG_OVERLAY:    cfg_nxt.overlay    = cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r           <= '0;
      cfg_r.font_size <= FONT_SIZE_RST;
      ld_r            <= '0;
    end else begin
      cfg_r <= cfg_nxt;
      ld_r  <= ld_nxt;
    end
  end

  // reload request is registered along with the origin write so the cursor sees the new origin
  assign cfg = cfg_r;
  assign ld  = ld_r;

endmodule

### hw/rtl/mwtl_layout.sv
// input register, cursor state and glyph placement logic
module mwtl_layout import mwtl_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,
  input  cfg_t       cfg,
  input  origin_ld_t ld,
  input  logic       can_load,
  output logic       res_valid,
  output result_t    res
);

  logic        in_valid_r, in_valid_nxt;
  logic [7:0]  in_byte_r;
  logic [15:0] cx_r, cx_nxt;
  logic [15:0] cy_r, cy_nxt;
  logic [7:0]  lead_r, lead_nxt;
  logic        pend_r, pend_nxt;
  logic        skip_r, skip_nxt;
  logic        full_r, full_nxt;

  logic        go;
  logic [6:0]  half;
  logic [7:0]  adv;
  logic        wrap;
  logic        fits;
  logic [15:0] cx_w, cy_w;
  logic        emit;
  logic [7:0]  b;

  // one byte moves from the input register per cycle when the result side is free
  assign go        = in_valid_r & can_load;
  assign in_tready = ~in_valid_r | can_load;
  assign b         = in_byte_r;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (go) in_valid_nxt = 1'b0;
    if (in_tvalid & in_tready) in_valid_nxt = 1'b1;
  end

  // wrap and fit tests, bounds compared wide so they never wrap
  assign half = cfg.font_size[7:1];
  assign adv  = pend_r ? cfg.font_size : {1'b0, half};
  assign wrap = ({1'b0, cx_r} + {9'd0, adv}) > ({1'b0, cfg.origin_x} + {1'b0, cfg.box_width});
  assign cx_w = wrap ? cfg.origin_x : cx_r;
  assign cy_w = wrap ? (cy_r + {8'd0, cfg.font_size}) : cy_r;
  assign fits = ({1'b0, cy_w} + {9'd0, cfg.font_size})
                <= ({1'b0, cfg.origin_y} + {1'b0, cfg.box_height});

  // per-byte state update
  always_comb begin
    cx_nxt   = cx_r;
    cy_nxt   = cy_r;
    lead_nxt = lead_r;
    pend_nxt = pend_r;
    skip_nxt = skip_r;
    full_nxt = full_r;
    emit     = 1'b0;
    res      = '0;
    res.draw_x      = cx_w;
    res.draw_y      = cy_w;
    res.transparent = cfg.overlay;
    if (go) begin
      if (b == BYTE_END) begin
        cx_nxt   = cfg.origin_x;
        cy_nxt   = cfg.origin_y;
        lead_nxt = '0;
        pend_nxt = 1'b0;
        skip_nxt = 1'b0;
        full_nxt = 1'b0;
      end else if (full_r) begin
        // box full: ignore until end of string
      end else if (skip_r) begin
        skip_nxt = 1'b0;
      end else if (pend_r) begin
        // trail byte of a full-width glyph
        pend_nxt = 1'b0;
        cx_nxt   = cx_w;
        cy_nxt   = cy_w;
        if (!fits) begin
          full_nxt = 1'b1;
        end else begin
          emit           = 1'b1;
          res.glyph_code = {lead_r, b};
          res.glyph_wide = 1'b1;
          cx_nxt         = cx_w + {8'd0, cfg.font_size};
        end
      end else if (b > LEAD_MIN) begin
        lead_nxt = b;
        pend_nxt = 1'b1;
      end else begin
        // half-width byte or line break
        cx_nxt = cx_w;
        cy_nxt = cy_w;
        if (!fits) begin
          full_nxt = 1'b1;
        end else if (b == BYTE_CR) begin
          cy_nxt   = cy_w + {8'd0, cfg.font_size};
          cx_nxt   = cfg.origin_x + {9'd0, half};
          skip_nxt = 1'b1;
        end else begin
          emit           = 1'b1;
          res.glyph_code = {8'd0, b};
          cx_nxt         = cx_w + {9'd0, half};
        end
      end
    end
    // origin writes reload the cursor
    if (ld.ld_x) cx_nxt = cfg.origin_x;
    if (ld.ld_y) cy_nxt = cfg.origin_y;
  end

  assign res_valid = go & emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
      cx_r       <= '0;
      cy_r       <= '0;
      lead_r     <= '0;
      pend_r     <= 1'b0;
      skip_r     <= 1'b0;
      full_r     <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
      cx_r       <= cx_nxt;
      cy_r       <= cy_nxt;
      lead_r     <= lead_nxt;
      pend_r     <= pend_nxt;
      skip_r     <= skip_nxt;
      full_r     <= full_nxt;
    end
  end

  // input payload register
  always_ff @(posedge clk) begin
    if (in_tvalid & in_tready) in_byte_r <= in_tdata;
  end

endmodule

### hw/rtl/mwtl_out_reg.sv
// result register holding one placed glyph until the sink takes it
module mwtl_out_reg import mwtl_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        res_valid,
  input  result_t     res,
  output logic        can_load,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,
  output logic        out_tuser
);

  logic    out_valid_r, out_valid_nxt;
  result_t res_r;

  assign can_load = ~out_valid_r | out_tready;

  // valid flag: set on load, cleared when the beat is taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r & out_tready) out_valid_nxt = 1'b0;
    if (res_valid) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= out_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (res_valid) res_r <= res;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, res_r.transparent, res_r.glyph_code, res_r.draw_y, res_r.draw_x};
  assign out_tuser  = res_r.glyph_wide;

endmodule
